@@ rtl/core/ffha_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int HDR_WORDS    = HEADER_BYTES / 4;
  localparam int SPLIT_MIN    = 2 * HEADER_BYTES;
  localparam int MIN_HEAP     = 32;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NO_SPACE  = 2'd1;
  localparam logic [1:0] STS_BAD_BLOCK = 2'd2;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  typedef enum logic [4:0] {
    OP_CLR, OP_IDLE, OP_DISP, OP_LCHK, OP_RCHK, OP_G1, OP_G2, OP_G3,
    OP_AWALK, OP_AHIT, OP_SP1, OP_SP2, OP_SP3, OP_FRD, OP_FLD, OP_FCLR,
    OP_FNCHK, OP_FM1, OP_FM2, OP_FM3, OP_FPRD, OP_FPCHK, OP_FP2, OP_FP3,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic take;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic k_alloc;
    logic k_look;
    logic mvreq;
    logic lbad;
    logic hbad;
    logic shrink;
    logic rd_next_zero;
    logic rd_used;
    logic grow_ok;
    logic fit;
    logic split_ok;
    logic nx_zero;
    logic s_zero;
    logic grow;
  } dp_status_t;

endpackage

@@ rtl/core/ffha_req_if.sv @@
// Request channel: valid/ready handshake and request word.
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] request_size;
  logic        has_address;
  logic [31:0] block_address;

  modport source(output valid, req_type, request_size, has_address, block_address,
                 input ready);
  modport sink(input valid, req_type, request_size, has_address, block_address,
               output ready);
endinterface

@@ rtl/core/ffha_rsp_if.sv @@
// Result channel: valid/ready handshake and result word.
interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [1:0]  status;
  logic        moved;
  logic [31:0] copy_from;
  logic [15:0] copy_bytes;

  modport source(output valid, result_address, status, moved, copy_from, copy_bytes,
                 input ready);
  modport sink(input valid, result_address, status, moved, copy_from, copy_bytes,
               output ready);
endinterface

@@ rtl/core/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator top level.
// One request at a time, from accept to result word: alloc walks the headers first fit and
// may split the found block; free releases the block and merges it with free neighbours;
// realloc works in place or moves, a moved realloc walking the headers and possibly splitting.
// The next request can be taken in the cycle after the result word loads.
// Reset and every configuration write start a clearing pass over all HEAP_MAX_BYTES/4 header
// slots (16384 by default), during which no request is taken.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int HEAP_MAX_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  ffha_req_if.sink    req,
  ffha_rsp_if.source  rsp
);

  cmd_t       cmd;
  dp_status_t sts;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd)
  );

  ffha_dp #(
    .HEAP_MAX_BYTES (HEAP_MAX_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req.req_type),
    .request_size   (req.request_size),
    .has_address    (req.has_address),
    .block_address  (req.block_address),
    .cmd            (cmd),
    .sts            (sts),
    .result_address (rsp.result_address),
    .status         (rsp.status),
    .moved          (rsp.moved),
    .copy_from      (rsp.copy_from),
    .copy_bytes     (rsp.copy_bytes)
  );

`ifndef SYNTH
  a_clr_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CLR) |-> !req.ready)
    else $error("request taken during clearing pass");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !req.ready)
    else $error("config write did not restart clearing");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp.valid)
    else $error("loaded result word not presented");
`endif

endmodule

@@ rtl/core/ffha_dp.sv @@
// Allocator datapath: header memory, working registers and result register.
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int HEAP_MAX_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  req_type,
  input  logic [15:0] request_size,
  input  logic        has_address,
  input  logic [31:0] block_address,
  input  cmd_t        cmd,
  output dp_status_t  sts,
  output logic [31:0] result_address,
  output logic [1:0]  status,
  output logic        moved,
  output logic [31:0] copy_from,
  output logic [15:0] copy_bytes
);

  localparam int SLOTS = HEAP_MAX_BYTES / 4;
  localparam int SLW   = $clog2(SLOTS);
  localparam int SW    = $clog2(HEAP_MAX_BYTES);
  localparam int XW    = (SW > 17 ? SW : 17) + 1;

  logic [31:0] heap_base;
  logic [16:0] heap_bytes;
  logic [SLW-1:0] clr_cnt;

  logic [1:0]  t;
  logic [16:0] rsize;
  logic        has;
  logic [31:0] addr;
  logic [SLW-1:0] s, w, wnext, nslot, pv, nx;
  logic [SW-1:0]  old, sz, wsz;
  logic        grow;
  logic [31:0] res, from;
  logic [1:0]  st_w;
  logic        mv;
  logic [15:0] bytes;

  logic           mem_used  [SLOTS];
  logic           mem_valid [SLOTS];
  logic [SW-1:0]  mem_size  [SLOTS];
  logic [SLW-1:0] mem_prev  [SLOTS];
  logic [SLW-1:0] mem_next  [SLOTS];

  logic           rd_used, rd_valid;
  logic [SW-1:0]  rd_size;
  logic [SLW-1:0] rd_prev, rd_next;

  logic           we_used, we_valid, we_size, we_prev, we_next;
  logic [SLW-1:0] waddr, raddr;
  logic           d_used, d_valid;
  logic [SW-1:0]  d_size;
  logic [SLW-1:0] d_prev, d_next;

  logic [XW-1:0] hb_ext, eff, rsz_x, rdsz_x, old_x, wsz_x, sz_x, comb_x, sum_x;
  logic [31:0]   off, w_addr;
  logic [SLW-1:0] lslot, m;
  logic [SW-1:0]  rest;
  logic           k_alloc, k_look;

  // effective heap size
  assign hb_ext = XW'(heap_bytes);
  always_comb begin
    eff = hb_ext;
    if (hb_ext < XW'(MIN_HEAP)) eff = XW'(MIN_HEAP);
    if (hb_ext > XW'(HEAP_MAX_BYTES)) eff = XW'(HEAP_MAX_BYTES);
    eff[1:0] = 2'b00;
  end

  assign off    = addr - heap_base - 32'(HEADER_BYTES);
  assign lslot  = off[SLW+1:2];
  assign w_addr = heap_base + 32'({w, 2'b00}) + 32'(HEADER_BYTES);

  assign rsz_x  = XW'(rsize);
  assign rdsz_x = XW'(rd_size);
  assign old_x  = XW'(old);
  assign wsz_x  = XW'(wsz);
  assign sz_x   = XW'(sz);
  assign comb_x = old_x + XW'(HEADER_BYTES) + rdsz_x;
  assign sum_x  = sz_x + XW'(HEADER_BYTES) + rdsz_x;
  assign m      = w + SLW'(HDR_WORDS) + SLW'(rsize >> 2);
  assign rest   = SW'(wsz_x - XW'(HEADER_BYTES) - rsz_x);

  assign k_alloc = (t == REQ_ALLOC) || (t == REQ_REALLOC && !has);
  assign k_look  = (t == REQ_FREE || t == REQ_REALLOC) && has;

  always_comb begin
    sts.clr_last     = (clr_cnt == SLW'(SLOTS - 1));
    sts.k_alloc      = k_alloc;
    sts.k_look       = k_look;
    sts.mvreq        = (t == REQ_REALLOC) && has;
    sts.lbad         = (off[1:0] != 2'b00) || (off[31:2] >= 30'(SLOTS));
    sts.hbad         = !rd_valid || !rd_used;
    sts.shrink       = rsz_x <= rdsz_x;
    sts.rd_next_zero = (rd_next == '0);
    sts.rd_used      = rd_used;
    sts.grow_ok      = !rd_used && (comb_x >= rsz_x);
    sts.fit          = !rd_used && (rdsz_x >= rsz_x);
    sts.split_ok     = wsz_x >= rsz_x + XW'(SPLIT_MIN);
    sts.nx_zero      = (nx == '0);
    sts.s_zero       = (s == '0);
    sts.grow         = grow;
  end

  // memory port control
  always_comb begin
    we_used = 1'b0; we_valid = 1'b0; we_size = 1'b0; we_prev = 1'b0; we_next = 1'b0;
    waddr = s; raddr = s;
    d_used = 1'b0; d_valid = 1'b0; d_size = '0; d_prev = '0; d_next = '0;
    case (cmd.op)
      OP_CLR: begin
        {we_used, we_valid, we_size, we_prev, we_next} = 5'b11111;
        waddr = clr_cnt;
        if (clr_cnt == '0) begin
          d_valid = 1'b1;
          d_size  = SW'(eff - XW'(HEADER_BYTES));
        end
      end
      OP_DISP: raddr = k_alloc ? '0 : lslot;
      OP_LCHK: raddr = rd_next;
      OP_RCHK: raddr = '0;
      OP_G1: begin
        we_valid = 1'b1; waddr = nslot;
      end
      OP_G2: begin
        we_size = 1'b1; we_next = 1'b1; d_size = wsz; d_next = wnext;
      end
      OP_G3: begin
        we_prev = (wnext != '0); waddr = wnext; d_prev = s;
      end
      OP_AWALK: raddr = rd_next;
      OP_AHIT: begin
        we_used = 1'b1; waddr = w; d_used = 1'b1;
      end
      OP_SP1: begin
        we_used = 1'b1; we_size = 1'b1; we_next = 1'b1; waddr = w;
        d_used = 1'b1; d_size = SW'(rsize); d_next = m;
      end
      OP_SP2: begin
        {we_used, we_valid, we_size, we_prev, we_next} = 5'b11111;
        waddr = m; d_valid = 1'b1; d_size = rest; d_prev = w; d_next = wnext;
      end
      OP_SP3: begin
        we_prev = (wnext != '0); waddr = wnext; d_prev = m;
      end
      OP_FRD: raddr = s;
      OP_FCLR: begin
        we_used = 1'b1; raddr = nx;
      end
      OP_FM1: begin
        we_valid = 1'b1; waddr = nslot;
      end
      OP_FM2: begin
        we_size = 1'b1; we_next = 1'b1; d_size = sz; d_next = nx;
      end
      OP_FM3: begin
        we_prev = (nx != '0); waddr = nx; d_prev = s;
      end
      OP_FPRD: raddr = pv;
      OP_FPCHK: begin
        we_size = !rd_used; we_next = !rd_used; waddr = pv;
        d_size = SW'(sum_x); d_next = nx;
      end
      OP_FP2: we_valid = 1'b1;
      OP_FP3: begin
        we_prev = (nx != '0); waddr = nx; d_prev = pv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_used)  mem_used[waddr]  <= d_used;
    if (we_valid) mem_valid[waddr] <= d_valid;
    if (we_size)  mem_size[waddr]  <= d_size;
    if (we_prev)  mem_prev[waddr]  <= d_prev;
    if (we_next)  mem_next[waddr]  <= d_next;
    rd_used  <= mem_used[raddr];
    rd_valid <= mem_valid[raddr];
    rd_size  <= mem_size[raddr];
    rd_prev  <= mem_prev[raddr];
    rd_next  <= mem_next[raddr];
  end

  // configuration and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_bytes <= 17'd65536;
      clr_cnt    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAP_BASE:  heap_base  <= cfg_data;
        CFG_HEAP_BYTES: heap_bytes <= cfg_data[16:0];
        default: ;
      endcase
      clr_cnt <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_IDLE: begin
        if (cmd.take) begin
          t     <= req_type;
          rsize <= ({1'b0, request_size} + 17'd3) & ~17'd3;
          has   <= has_address;
          addr  <= block_address;
          res   <= '0;
          st_w  <= STS_OK;
          mv    <= 1'b0;
          from  <= '0;
          bytes <= '0;
          grow  <= 1'b0;
        end
      end
      OP_DISP: begin
        s <= lslot;
        w <= '0;
        if (k_look && sts.lbad) st_w <= STS_BAD_BLOCK;
      end
      OP_LCHK: begin
        w <= '0;
        if (sts.hbad) begin
          st_w <= STS_BAD_BLOCK;
        end else begin
          old   <= rd_size;
          sz    <= rd_size;
          nx    <= rd_next;
          pv    <= rd_prev;
          nslot <= rd_next;
          if (t == REQ_REALLOC && sts.shrink) res <= addr;
        end
      end
      OP_RCHK: begin
        if (sts.grow_ok) begin
          wsz   <= SW'(comb_x);
          wnext <= rd_next;
          w     <= s;
          res   <= addr;
          grow  <= 1'b1;
        end else begin
          w <= '0;
        end
      end
      OP_AWALK: begin
        if (sts.fit) begin
          wsz   <= rd_size;
          wnext <= rd_next;
        end else if (rd_next == '0) begin
          st_w <= STS_NO_SPACE;
        end else begin
          w <= rd_next;
        end
      end
      OP_AHIT: begin
        res <= w_addr;
        if (sts.mvreq) begin
          mv    <= 1'b1;
          from  <= addr;
          bytes <= 16'(old);
        end
      end
      OP_FLD: begin
        sz <= rd_size;
        nx <= rd_next;
        pv <= rd_prev;
      end
      OP_FCLR: nslot <= nx;
      OP_FNCHK: begin
        if (!rd_used) begin
          sz <= SW'(sum_x);
          nx <= rd_next;
        end
      end
      OP_DONE: begin
        if (cmd.load_out) begin
          result_address <= res;
          status         <= st_w;
          moved          <= mv;
          copy_from      <= from;
          copy_bytes     <= bytes;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/ffha_ctrl.sv @@
// Allocator controller: request sequencing and result handshake.
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       req_valid,
  input  logic       rsp_ready,
  input  dp_status_t sts,
  output logic       req_ready,
  output logic       rsp_valid,
  output cmd_t       cmd
);

  typedef enum logic [24:0] {
    S_CLR   = 25'h0000001, S_IDLE  = 25'h0000002, S_DISP  = 25'h0000004,
    S_LCHK  = 25'h0000008, S_RCHK  = 25'h0000010, S_G1    = 25'h0000020,
    S_G2    = 25'h0000040, S_G3    = 25'h0000080, S_AWALK = 25'h0000100,
    S_AHIT  = 25'h0000200, S_SP1   = 25'h0000400, S_SP2   = 25'h0000800,
    S_SP3   = 25'h0001000, S_FRD   = 25'h0002000, S_FLD   = 25'h0004000,
    S_FCLR  = 25'h0008000, S_FNCHK = 25'h0010000, S_FM1   = 25'h0020000,
    S_FM2   = 25'h0040000, S_FM3   = 25'h0080000, S_FPRD  = 25'h0100000,
    S_FPCHK = 25'h0200000, S_FP2   = 25'h0400000, S_FP3   = 25'h0800000,
    S_DONE  = 25'h1000000
  } state_t;

  state_t state, state_next;
  op_t    op;
  logic   load_out;

  assign req_ready    = (state == S_IDLE);
  assign load_out     = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign cmd.op       = op;
  assign cmd.take     = (state == S_IDLE) && req_valid;
  assign cmd.load_out = load_out;

  always_comb begin
    state_next = state;
    op = OP_IDLE;
    case (state)
      S_CLR: begin
        op = OP_CLR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        op = OP_IDLE;
        if (req_valid) state_next = S_DISP;
      end
      S_DISP: begin
        op = OP_DISP;
        if (sts.k_alloc) state_next = S_AWALK;
        else if (sts.k_look && !sts.lbad) state_next = S_LCHK;
        else state_next = S_DONE;
      end
      S_LCHK: begin
        op = OP_LCHK;
        if (sts.hbad) state_next = S_DONE;
        else if (!sts.mvreq) state_next = S_FCLR;
        else if (sts.shrink) state_next = S_DONE;
        else if (sts.rd_next_zero) state_next = S_AWALK;
        else state_next = S_RCHK;
      end
      S_RCHK: begin
        op = OP_RCHK;
        state_next = sts.grow_ok ? S_G1 : S_AWALK;
      end
      S_G1: begin
        op = OP_G1;
        state_next = S_G2;
      end
      S_G2: begin
        op = OP_G2;
        state_next = S_G3;
      end
      S_G3: begin
        op = OP_G3;
        state_next = sts.split_ok ? S_SP1 : S_DONE;
      end
      S_AWALK: begin
        op = OP_AWALK;
        if (sts.fit) state_next = S_AHIT;
        else if (sts.rd_next_zero) state_next = S_DONE;
      end
      S_AHIT: begin
        op = OP_AHIT;
        if (sts.split_ok) state_next = S_SP1;
        else if (sts.mvreq) state_next = S_FRD;
        else state_next = S_DONE;
      end
      S_SP1: begin
        op = OP_SP1;
        state_next = S_SP2;
      end
      S_SP2: begin
        op = OP_SP2;
        state_next = S_SP3;
      end
      S_SP3: begin
        op = OP_SP3;
        state_next = (!sts.grow && sts.mvreq) ? S_FRD : S_DONE;
      end
      S_FRD: begin
        op = OP_FRD;
        state_next = S_FLD;
      end
      S_FLD: begin
        op = OP_FLD;
        state_next = S_FCLR;
      end
      S_FCLR: begin
        op = OP_FCLR;
        state_next = sts.nx_zero ? S_FPRD : S_FNCHK;
      end
      S_FNCHK: begin
        op = OP_FNCHK;
        state_next = sts.rd_used ? S_FPRD : S_FM1;
      end
      S_FM1: begin
        op = OP_FM1;
        state_next = S_FM2;
      end
      S_FM2: begin
        op = OP_FM2;
        state_next = S_FM3;
      end
      S_FM3: begin
        op = OP_FM3;
        state_next = S_FPRD;
      end
      S_FPRD: begin
        op = OP_FPRD;
        state_next = sts.s_zero ? S_DONE : S_FPCHK;
      end
      S_FPCHK: begin
        op = OP_FPCHK;
        state_next = sts.rd_used ? S_DONE : S_FP2;
      end
      S_FP2: begin
        op = OP_FP2;
        state_next = S_FP3;
      end
      S_FP3: begin
        op = OP_FP3;
        state_next = S_DONE;
      end
      S_DONE: begin
        op = OP_DONE;
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
    if (cfg_we) state_next = S_CLR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule
